### src/plp_pkg.sv
// Shared types, constants and helpers for the policy language lexer.
// Holds the token record, token kinds, character codes and keyword table.
// No dependencies.
package plp_pkg;

	localparam int PosBits = 16;
	localparam int KwCount = 7;
	localparam logic [15:0] LenMax = 16'hFFFF;

	typedef logic [PosBits-1:0] pos_t;

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_POLICY  = 4'd1,
		KIND_END_KW  = 4'd2,
		KIND_REFUSAL = 4'd3,
		KIND_APPEND  = 4'd4,
		KIND_REDACT  = 4'd5,
		KIND_FORBID  = 4'd6,
		KIND_TEXT    = 4'd7,
		KIND_COMMA   = 4'd8,
		KIND_LPAR    = 4'd9,
		KIND_RPAR    = 4'd10,
		KIND_COLON   = 4'd11,
		KIND_ILLEGAL = 4'd12,
		KIND_END     = 4'd13
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChLpar  = 8'h28;
	localparam logic [7:0] ChRpar  = 8'h29;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChUscore = 8'h5F;

	// keywords left-justified, padded to eight characters
	localparam logic [63:0] KwText [KwCount] = '{
		"policy  ", "end     ", "refusal ", "append  ",
		"redact  ", "forbid  ", "text    "
	};
	localparam logic [2:0] KwLen [KwCount] = '{
		3'd6, 3'd3, 3'd7, 3'd6, 3'd6, 3'd6, 3'd4
	};

	function automatic logic [7:0] kw_char(input logic [63:0] text, input logic [2:0] idx);
		logic [5:0] sh;
		sh = {3'd7 - idx, 3'b000};
		return text[sh +: 8];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == ChTab || c == ChCr || c == ChLf || c == ChSpace;
	endfunction

	function automatic logic [15:0] pos_low16(input pos_t p);
		logic [PosBits+15:0] w;
		w = {16'b0, p};
		return w[15:0];
	endfunction

endpackage

### src/plp_lex.sv
// Lexer state and token generation for one character per cycle while fire is raised.
// Holds position, word start, word length and keyword match bits.
// Depends on plp_pkg.
module plp_lex (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       char_byte,
	output logic [1:0]       n_tok,
	output plp_pkg::tok_t    tok0,
	output plp_pkg::tok_t    tok1
);

	plp_pkg::pos_t pos_q, pos_d, ws_q, ws_d, pos_inc;
	logic                      in_word_q, in_word_d;
	logic [15:0]               wl_q, wl_d, wl_base, wl_track;
	logic [plp_pkg::KwCount-1:0] alive_q, alive_d, alive_base, alive_track;
	plp_pkg::kind_t            word_kind, punct_kind;
	plp_pkg::tok_t             t2;
	logic                      cont, letter, has2;

	assign letter  = plp_pkg::is_letter(char_byte);
	assign cont    = in_word_q && (letter || char_byte == plp_pkg::ChUscore);
	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	assign wl_base    = cont ? wl_q : 16'd0;
	assign alive_base = cont ? alive_q : '1;
	assign wl_track   = (wl_base == plp_pkg::LenMax) ? wl_base : wl_base + 16'd1;

	always_comb begin
		for (int i = 0; i < plp_pkg::KwCount; i++) begin
			alive_track[i] = alive_base[i] && (wl_base < {13'b0, plp_pkg::KwLen[i]}) &&
				(plp_pkg::kw_char(plp_pkg::KwText[i], wl_base[2:0]) == char_byte);
		end
	end

	always_comb begin
		word_kind = plp_pkg::KIND_IDENT;
		for (int i = plp_pkg::KwCount - 1; i >= 0; i--) begin
			if (alive_q[i] && wl_q == {13'b0, plp_pkg::KwLen[i]})
				word_kind = plp_pkg::kind_t'(4'(i + 1));
		end
	end

	always_comb begin
		unique case (char_byte)
			plp_pkg::ChComma: punct_kind = plp_pkg::KIND_COMMA;
			plp_pkg::ChLpar:  punct_kind = plp_pkg::KIND_LPAR;
			plp_pkg::ChRpar:  punct_kind = plp_pkg::KIND_RPAR;
			plp_pkg::ChColon: punct_kind = plp_pkg::KIND_COLON;
			default:          punct_kind = plp_pkg::KIND_ILLEGAL;
		endcase
	end

	always_comb begin
		pos_d     = pos_q;
		in_word_d = in_word_q;
		ws_d      = ws_q;
		wl_d      = wl_q;
		alive_d   = alive_q;
		n_tok     = 2'd0;
		tok0      = '0;
		tok1      = '0;
		t2        = '0;
		has2      = 1'b0;
		if (fire) begin
			if (cont) begin
				alive_d = alive_track;
				wl_d    = wl_track;
				pos_d   = pos_inc;
			end else begin
				if (in_word_q) begin
					tok0.kind   = word_kind;
					tok0.start  = plp_pkg::pos_low16(ws_q);
					tok0.length = wl_q;
					n_tok       = 2'd1;
					in_word_d   = 1'b0;
				end
				if (char_byte == plp_pkg::ChNul) begin
					has2      = 1'b1;
					t2.kind   = plp_pkg::KIND_END;
					t2.start  = plp_pkg::pos_low16(pos_q);
					t2.length = 16'd0;
					pos_d     = '0;
					in_word_d = 1'b0;
					ws_d      = '0;
					wl_d      = 16'd0;
					alive_d   = '1;
				end else begin
					pos_d = pos_inc;
					if (letter) begin
						in_word_d = 1'b1;
						ws_d      = pos_q;
						wl_d      = wl_track;
						alive_d   = alive_track;
					end else if (!plp_pkg::is_space(char_byte)) begin
						has2      = 1'b1;
						t2.kind   = punct_kind;
						t2.start  = plp_pkg::pos_low16(pos_q);
						t2.length = 16'd1;
					end
				end
				if (has2) begin
					if (in_word_q) begin
						tok1  = t2;
						n_tok = 2'd2;
					end else begin
						tok0  = t2;
						n_tok = 2'd1;
					end
				end
				tok0.last = (n_tok == 2'd1);
				tok1.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_word_q <= 1'b0;
			ws_q      <= '0;
			wl_q      <= 16'd0;
			alive_q   <= '1;
		end else begin
			pos_q     <= pos_d;
			in_word_q <= in_word_d;
			ws_q      <= ws_d;
			wl_q      <= wl_d;
			alive_q   <= alive_d;
		end
	end

`ifndef SYNTHESIS
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && char_byte == plp_pkg::ChNul |=> pos_q == '0 && !in_word_q)
		else $error("state not cleared after end of text");
	a_word_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_word_q |-> wl_q != 16'd0)
		else $error("word in progress with zero length");
	a_cont_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cont |-> n_tok == 2'd0)
		else $error("token emitted while a word continues");
`endif

endmodule

### src/plp_tok_fifo.sv
// Four-entry token queue between the lexer and the output channel.
// Takes up to two tokens per cycle, gives one per transfer.
// Depends on plp_pkg.
module plp_tok_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  plp_pkg::tok_t  push0,
	input  plp_pkg::tok_t  push1,
	output logic           room,
	output logic           token_valid,
	input  logic           token_stall,
	output logic [3:0]     token_kind,
	output logic [15:0]    token_start,
	output logic [15:0]    token_length,
	output logic           last_of_run
);

	plp_pkg::tok_t entry_q [4];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    count_q, count_d;
	logic          pop;
	plp_pkg::tok_t head;

	assign token_valid = count_q != 3'd0;
	assign pop         = token_valid && !token_stall;
	assign room        = (count_q <= 3'd2) || (pop && count_q == 3'd3);
	assign count_d     = count_q + {1'b0, push_n} - {2'b0, pop};

	assign head         = entry_q[rd_q];
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			entry_q[wr_q] <= push0;
		if (push_n == 2'd2)
			entry_q[wr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push_n;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("token queue over capacity");
	a_ptr_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_q + count_q[1:0]) == wr_q)
		else $error("queue pointers disagree with count");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> push_n != 2'd3 && count_d <= 3'd4)
		else $error("push into full token queue");
`endif

endmodule

### src/policy_language_lexer.sv
// Top level of the policy language lexer.
// Input register, lexer core (plp_lex) and token queue (plp_tok_fifo).
// Depends on plp_pkg.
//
// Use:
//   Characters enter on char_valid/char_stall with char_byte; a zero byte
//   ends the text. Tokens leave on token_valid/token_stall with token_kind,
//   token_start, token_length and last_of_run; last_of_run marks the final
//   token a character causes. A character gives no token, one token, or two
//   (a word token followed by the token of the character that ended it).
//   Path: a taken character is held in the input register, lexed from there,
//   and its tokens are written into the token queue before they can transfer.
//   Throughput: one character per cycle while the receiver takes a token
//   every cycle; a word ended by punctuation or end of text needs two token
//   transfers, which the four-entry token queue absorbs.
//   Stall: the input register holds a character until the queue has room
//   for two tokens, and char_stall is raised while it holds.
//   Reset: position, word state and queue are cleared; no token is pending.
//   After an end token the position starts again at zero.
module policy_language_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          room, fire;
	logic [1:0]    n_tok;
	plp_pkg::tok_t tok0, tok1;

	assign fire       = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall)
			char_s1 <= char_byte;
	end

	plp_lex u_lex (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_byte (char_s1),
		.n_tok     (n_tok),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	plp_tok_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_n       (n_tok),
		.push0        (tok0),
		.push1        (tok1),
		.room         (room),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

### tb/plp_token_checker.sv
// Token checker for the policy language lexer testbench.
// Watches both channels, predicts the tokens of every character transfer and compares.
// Depends on plp_pkg.
module plp_token_checker import plp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  logic [7:0]  char_byte,
	input  logic        token_valid,
	input  logic        token_stall,
	input  logic [3:0]  token_kind,
	input  logic [15:0] token_start,
	input  logic [15:0] token_length,
	input  logic        last_of_run,
	output int          mismatches,
	output int          tokens_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	tok_t        token_q [$];
	logic [15:0] pos_q;
	logic        word_q;
	logic [15:0] wstart_q;
	logic [15:0] wlen_q;
	logic [6:0]  alive_q;
	int          errors;

	function automatic string keyword(input int idx);
		case (idx)
			0: return "policy";
			1: return "end";
			2: return "refusal";
			3: return "append";
			4: return "redact";
			5: return "forbid";
			default: return "text";
		endcase
	endfunction

	function automatic logic alpha(input logic [7:0] c);
		logic [7:0] u;
		u = c & 8'hDF;
		return u >= 8'h41 && u <= 8'h5A;
	endfunction

	task automatic clear_lexer();
		pos_q = '0;
		word_q = 1'b0;
		wstart_q = '0;
		wlen_q = '0;
		alive_q = '1;
	endtask

	task automatic follow(input logic [7:0] c);
		string w;
		int    i;
		for (i = 0; i < 7; i++) begin
			w = keyword(i);
			if (wlen_q >= w.len() || w[wlen_q] != c)
				alive_q[i] = 1'b0;
		end
		if (wlen_q != 16'hFFFF)
			wlen_q++;
	endtask

	function automatic kind_t word_kind();
		string w;
		int    i;
		for (i = 0; i < 7; i++) begin
			w = keyword(i);
			if (alive_q[i] && wlen_q == w.len())
				return kind_t'(i + 1);
		end
		return KIND_IDENT;
	endfunction

	task automatic lex(input logic [7:0] c);
		tok_t        word_tok;
		tok_t        own_tok;
		logic        has_word;
		logic        has_own;
		logic [15:0] at;
		at = pos_q;
		has_word = 1'b0;
		has_own = 1'b0;
		word_tok = '0;
		own_tok = '0;
		if (word_q && (alpha(c) || c == ChUscore)) begin
			follow(c);
			if (pos_q != 16'hFFFF)
				pos_q++;
			return;
		end
		if (word_q) begin
			word_tok.kind = word_kind();
			word_tok.start = wstart_q;
			word_tok.length = wlen_q;
			has_word = 1'b1;
			word_q = 1'b0;
		end
		if (c == ChNul) begin
			own_tok.kind = KIND_END;
			own_tok.start = at;
			own_tok.length = '0;
			has_own = 1'b1;
			clear_lexer();
		end else begin
			if (pos_q != 16'hFFFF)
				pos_q++;
			if (alpha(c)) begin
				word_q = 1'b1;
				wstart_q = at;
				wlen_q = '0;
				alive_q = '1;
				follow(c);
			end else begin
				has_own = 1'b1;
				own_tok.start = at;
				own_tok.length = 16'd1;
				case (c)
					ChTab, ChCr, ChLf, ChSpace: has_own = 1'b0;
					ChComma: own_tok.kind = KIND_COMMA;
					ChLpar:  own_tok.kind = KIND_LPAR;
					ChRpar:  own_tok.kind = KIND_RPAR;
					ChColon: own_tok.kind = KIND_COLON;
					default: own_tok.kind = KIND_ILLEGAL;
				endcase
			end
		end
		if (has_word) begin
			word_tok.last = !has_own;
			token_q.push_back(word_tok);
		end
		if (has_own) begin
			own_tok.last = 1'b1;
			token_q.push_back(own_tok);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : compare
		tok_t want;
		if (!arst_n) begin
			clear_lexer();
			token_q.delete();
			errors = 0;
			mismatches <= 0;
			tokens_pending <= 0;
		end else begin
			if (token_valid && !token_stall) begin
				if (token_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected token: expected none, actual kind %0d start %0d length %0d last %0b",
						$time, token_kind, token_start, token_length, last_of_run);
				end else begin
					want = token_q.pop_front();
					if (want.kind !== token_kind || want.start !== token_start ||
							want.length !== token_length || want.last !== last_of_run) begin
						errors++;
						$display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0b",
							$time, want.kind, want.start, want.length, want.last);
						$display("%0t:                 actual   kind %0d start %0d length %0d last %0b",
							$time, token_kind, token_start, token_length, last_of_run);
					end
				end
			end
			if (char_valid && !char_stall)
				lex(char_byte);
			mismatches <= errors;
			tokens_pending <= token_q.size();
		end
	end

endmodule

### tb/tb_policy_language_lexer.sv
// Testbench top for the policy language lexer: clock, reset, character and token drivers.
// Runs directed text and random phases with idling and stalls.
// Depends on plp_pkg, policy_language_lexer and plp_token_checker.
module tb_policy_language_lexer;
	timeunit 1ns;
	timeprecision 1ps;
	import plp_pkg::*;

	localparam int WatchLimit = 2000;
	localparam int HoldCycles = 40;
	localparam int PhaseItems = 225;
	localparam int TailCycles = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_byte = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;
	int          mismatches;
	int          tokens_pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          chars_sent = 0;
	int          quiet_cycles = 0;
	logic        hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	policy_language_lexer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	plp_token_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_byte      (char_byte),
		.token_valid    (token_valid),
		.token_stall    (token_stall),
		.token_kind     (token_kind),
		.token_start    (token_start),
		.token_length   (token_length),
		.last_of_run    (last_of_run),
		.mismatches     (mismatches),
		.tokens_pending (tokens_pending)
	);

	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (token_valid && !token_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchLimit) begin
			$display("FAIL policy_language_lexer");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				token_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			token_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic string keyword_text(input int idx);
		case (idx)
			0: return "policy";
			1: return "end";
			2: return "refusal";
			3: return "append";
			4: return "redact";
			5: return "forbid";
			default: return "text";
		endcase
	endfunction

	function automatic logic [7:0] letter();
		int r;
		r = $urandom_range(51);
		return 8'((r < 26) ? 8'h61 + r : 8'h41 + r - 26);
	endfunction

	function automatic logic [7:0] tail_char();
		return ($urandom_range(4) == 0) ? ChUscore : letter();
	endfunction

	function automatic logic [7:0] blank();
		case ($urandom_range(3))
			0: return ChTab;
			1: return ChCr;
			2: return ChLf;
			default: return ChSpace;
		endcase
	endfunction

	function automatic logic [7:0] punct();
		case ($urandom_range(3))
			0: return ChComma;
			1: return ChLpar;
			2: return ChRpar;
			default: return ChColon;
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte <= c;
		do @(posedge clk); while (char_stall);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_word();
		string      w;
		int         i;
		int         n;
		logic       upper;
		logic [7:0] c;
		if ($urandom_range(99) < 60) begin
			w = keyword_text($urandom_range(6));
			n = w.len();
			upper = ($urandom_range(9) == 0);
			if ($urandom_range(9) == 0)
				n = n - 1;
			for (i = 0; i < n; i++) begin
				c = w[i];
				if (i == 0 && upper)
					c = c ^ 8'h20;
				send_char(c);
			end
			if ($urandom_range(9) == 0)
				send_char(tail_char());
		end else begin
			send_char(letter());
			n = $urandom_range(9);
			for (i = 0; i < n; i++)
				send_char(tail_char());
		end
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			send_word();
			r = $urandom_range(99);
			if (r < 40)
				send_char(blank());
			else if (r < 80)
				send_char(punct());
			else if (r < 86)
				send_char(ChNul);
			else if (r < 93)
				send_char(8'($urandom_range(255)));
		end else if (r < 72) begin
			send_char(($urandom_range(1) == 0) ? blank() : punct());
		end else if (r < 79) begin
			send_char(ChNul);
		end else if (r < 93) begin
			send_char(8'($urandom_range(255)));
		end else begin
			send_char(ChUscore);
		end
	endtask

	task automatic run_phase(input int count);
		int first;
		first = chars_sent;
		while (chars_sent - first < count)
			send_random();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("end(Policy_x,_):");
		send_char(ChTab);
		send_char(ChCr);
		send_char(ChLf);
		send_text(" text_ refusalz");
		send_char(8'hFF);
		send_char(8'h80);
		send_text("text");
		send_char(ChNul);
		run_phase(PhaseItems);

		idle_pct = 61;
		run_phase(PhaseItems);

		idle_pct = 0;
		stall_pct = 61;
		hold_req = 1'b1;
		run_phase(PhaseItems);

		idle_pct = 16;
		stall_pct = 16;
		run_phase(PhaseItems);
		char_valid <= 1'b0;

		do @(posedge clk); while (tokens_pending != 0);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && tokens_pending == 0)
			$display("PASS policy_language_lexer");
		else
			$display("FAIL policy_language_lexer");
		$finish;
	end

endmodule
